// ===== hdl/dwsp_pkg.sv =====
package dwsp_pkg;

	// Fixed-point and threshold settings
	localparam int GAIN_FRAC_BITS = 8;
	localparam int WRAP_THRESHOLD = 30000;

	// Field and state widths
	localparam int RAW_W  = 16;
	localparam int GAIN_W = 16;
	localparam int TGT_W  = 16;
	localparam int SPD_W  = 32;
	localparam int ERR_W  = 32;
	localparam int ESUM_W = 40;
	localparam int DRV_W  = 32;
	localparam int IDX_W  = 3;

	// Intermediate widths
	localparam int DELTA_W    = RAW_W + 1;
	localparam int SPD_RAW_W  = SPD_W + 1;
	localparam int ERR_RAW_W  = SPD_W + GAIN_FRAC_BITS + 1;
	localparam int ESUM_RAW_W = ESUM_W + 1;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int PE_W       = GAIN_W + ERR_W;
	localparam int PI_W       = GAIN_W + ESUM_W;
	localparam int PD_W       = GAIN_W + DIFF_W;
	localparam int ACC_W      = PI_W + 2;
	localparam int DRV_SHIFT  = 2 * GAIN_FRAC_BITS;

	typedef enum logic {
		CMD_TICK    = 1'b0,
		CMD_CONTROL = 1'b1
	} cmd_t;

	typedef enum logic [IDX_W-1:0] {
		REG_LEFT_P  = 3'd0,
		REG_LEFT_I  = 3'd1,
		REG_LEFT_D  = 3'd2,
		REG_RIGHT_P = 3'd3,
		REG_RIGHT_I = 3'd4,
		REG_RIGHT_D = 3'd5
	} reg_idx_t;

	// Gain register reset values
	localparam logic signed [GAIN_W-1:0] LEFT_P_RESET  = 16'sd25600;
	localparam logic signed [GAIN_W-1:0] LEFT_I_RESET  = 16'sd2560;
	localparam logic signed [GAIN_W-1:0] LEFT_D_RESET  = 16'sd0;
	localparam logic signed [GAIN_W-1:0] RIGHT_P_RESET = 16'sd26880;
	localparam logic signed [GAIN_W-1:0] RIGHT_I_RESET = 16'sd2688;
	localparam logic signed [GAIN_W-1:0] RIGHT_D_RESET = 16'sd0;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gains_t;

	// Stage enables for the wheel state tracker
	typedef struct packed {
		logic tick_en;
		logic ctrl_en;
	} track_ctl_t;

	// Stage enables for the PID arithmetic stages
	typedef struct packed {
		logic mul_en;
		logic out_en;
	} pid_ctl_t;

	// Counter above the threshold means a backward count (raw - 65536)
	function automatic logic signed [DELTA_W-1:0] unwrap_count(logic [RAW_W-1:0] raw);
		if (raw > RAW_W'(WRAP_THRESHOLD)) begin
			return $signed({1'b1, raw});
		end
		return $signed({1'b0, raw});
	endfunction

	function automatic logic signed [SPD_W-1:0] sat_spd(logic signed [SPD_RAW_W-1:0] v);
		if (v[SPD_RAW_W-1] == v[SPD_W-1]) begin
			return v[SPD_W-1:0];
		end
		return v[SPD_RAW_W-1] ? $signed({1'b1, {(SPD_W-1){1'b0}}})
			: $signed({1'b0, {(SPD_W-1){1'b1}}});
	endfunction

	function automatic logic signed [ERR_W-1:0] sat_err(logic signed [ERR_RAW_W-1:0] v);
		if ((&v[ERR_RAW_W-1:ERR_W-1]) || !(|v[ERR_RAW_W-1:ERR_W-1])) begin
			return v[ERR_W-1:0];
		end
		return v[ERR_RAW_W-1] ? $signed({1'b1, {(ERR_W-1){1'b0}}})
			: $signed({1'b0, {(ERR_W-1){1'b1}}});
	endfunction

	function automatic logic signed [ESUM_W-1:0] sat_esum(logic signed [ESUM_RAW_W-1:0] v);
		if (v[ESUM_RAW_W-1] == v[ESUM_W-1]) begin
			return v[ESUM_W-1:0];
		end
		return v[ESUM_RAW_W-1] ? $signed({1'b1, {(ESUM_W-1){1'b0}}})
			: $signed({1'b0, {(ESUM_W-1){1'b1}}});
	endfunction

	function automatic logic signed [DRV_W-1:0] sat_drv(logic signed [ACC_W-1:0] v);
		if ((&v[ACC_W-1:DRV_W-1]) || !(|v[ACC_W-1:DRV_W-1])) begin
			return v[DRV_W-1:0];
		end
		return v[ACC_W-1] ? $signed({1'b1, {(DRV_W-1){1'b0}}})
			: $signed({1'b0, {(DRV_W-1){1'b1}}});
	endfunction

endpackage

// ===== hdl/dwsp_track.sv =====
module dwsp_track (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dwsp_pkg::track_ctl_t                  ctl,
	input  logic signed [dwsp_pkg::DELTA_W-1:0]   delta,
	input  logic signed [dwsp_pkg::TGT_W-1:0]     target,
	output logic signed [dwsp_pkg::ERR_W-1:0]     err_s2,
	output logic signed [dwsp_pkg::ESUM_W-1:0]    esum_s2,
	output logic signed [dwsp_pkg::DIFF_W-1:0]    diff_s2
);
	import dwsp_pkg::*;

	logic signed [SPD_W-1:0]     speed_q;
	logic signed [ESUM_W-1:0]    esum_q;
	logic signed [ERR_W-1:0]     prev_q;

	logic signed [SPD_W-1:0]     speed_next;
	logic signed [ERR_RAW_W-1:0] speed_scaled;
	logic signed [ERR_RAW_W-1:0] err_raw;
	logic signed [ERR_W-1:0]     err;
	logic signed [ESUM_W-1:0]    esum_next;
	logic signed [DIFF_W-1:0]    diff;

	// Saturating speed sum, error and error sum, and the full-width error step
	always_comb begin
		speed_next   = sat_spd(SPD_RAW_W'(speed_q) + SPD_RAW_W'(delta));
		speed_scaled = ERR_RAW_W'(speed_q) <<< GAIN_FRAC_BITS;
		err_raw      = ERR_RAW_W'(target) - speed_scaled;
		err          = sat_err(err_raw);
		esum_next    = sat_esum(ESUM_RAW_W'(esum_q) + ESUM_RAW_W'(err));
		diff         = DIFF_W'(err) - DIFF_W'(prev_q);
	end

	// Wheel state: ticks accumulate the speed sum; a control item clears it and updates the error sum and previous error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			esum_q  <= '0;
			prev_q  <= '0;
		end else if (ctl.tick_en) begin
			speed_q <= speed_next;
		end else if (ctl.ctrl_en) begin
			speed_q <= '0;
			esum_q  <= esum_next;
			prev_q  <= err;
		end
	end

	// Terms handed to the multiply stage
	always_ff @(posedge clk) begin
		if (ctl.ctrl_en) begin
			err_s2  <= err;
			esum_s2 <= esum_next;
			diff_s2 <= diff;
		end
	end

endmodule

// ===== hdl/dwsp_pid.sv =====
module dwsp_pid (
	input  logic                                  clk,
	input  dwsp_pkg::pid_ctl_t                    ctl,
	input  dwsp_pkg::gains_t                      gains,
	input  logic signed [dwsp_pkg::ERR_W-1:0]     err,
	input  logic signed [dwsp_pkg::ESUM_W-1:0]    esum,
	input  logic signed [dwsp_pkg::DIFF_W-1:0]    diff,
	output logic signed [dwsp_pkg::DRV_W-1:0]     drive_q
);
	import dwsp_pkg::*;

	logic signed [PE_W-1:0]  pe_s3;
	logic signed [PI_W-1:0]  pi_s3;
	logic signed [PD_W-1:0]  pd_s3;

	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] bias;
	logic signed [ACC_W-1:0] acc_adj;
	logic signed [ACC_W-1:0] acc_shr;

	// One product per term, registered
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			pe_s3 <= PE_W'($signed(gains.kp) * err);
			pi_s3 <= PI_W'($signed(gains.ki) * esum);
			pd_s3 <= PD_W'($signed(gains.kd) * diff);
		end
	end

	// Sum, shift toward zero (bias negatives first), saturate
	always_comb begin
		acc     = ACC_W'(pe_s3) + ACC_W'(pi_s3) + ACC_W'(pd_s3);
		bias    = acc[ACC_W-1] ? $signed(ACC_W'((64'd1 << DRV_SHIFT) - 64'd1)) : '0;
		acc_adj = acc + bias;
		acc_shr = acc_adj >>> DRV_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_en) begin
			drive_q <= sat_drv(acc_shr);
		end
	end

endmodule

// ===== hdl/dual_wheel_speed_pid_top.sv =====
// Two-wheel speed PID controller.
// Throughput: one item per cycle, tick or control; back-pressure stalls controls.
// Path: a tick updates the speed sums in the cycle after it is taken; a control
// item's drives pass the input, error, multiply and output regs, and can stall.
// Reset: arst_n clears speed sums, error sums, previous errors and pipeline valids,
// and loads the gain registers with their default values.
module dual_wheel_speed_pid_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [dwsp_pkg::IDX_W-1:0]            cfg_index,
	input  logic [dwsp_pkg::GAIN_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [dwsp_pkg::RAW_W-1:0]            left_raw_count,
	input  logic [dwsp_pkg::RAW_W-1:0]            right_raw_count,
	input  logic signed [dwsp_pkg::TGT_W-1:0]     left_target,
	input  logic signed [dwsp_pkg::TGT_W-1:0]     right_target,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [dwsp_pkg::DRV_W-1:0]     left_drive,
	output logic signed [dwsp_pkg::DRV_W-1:0]     right_drive
);
	import dwsp_pkg::*;

	// Gain registers
	logic signed [GAIN_W-1:0] lp_q, li_q, ld_q, rp_q, ri_q, rd_q;

	// Input register
	logic                     valid_s1;
	cmd_t                     cmd_s1;
	logic [RAW_W-1:0]         lraw_s1, rraw_s1;
	logic signed [TGT_W-1:0]  ltgt_s1, rtgt_s1;

	logic valid_s2, valid_s3, out_valid_q;
	logic s1_go, s2_go, s3_go, accept;

	logic signed [DELTA_W-1:0] ldelta, rdelta;
	logic signed [ERR_W-1:0]   lerr_s2, rerr_s2;
	logic signed [ESUM_W-1:0]  lesum_s2, resum_s2;
	logic signed [DIFF_W-1:0]  ldiff_s2, rdiff_s2;

	track_ctl_t trk_ctl;
	pid_ctl_t   pid_ctl;
	gains_t     left_gains, right_gains;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= LEFT_P_RESET;
			li_q <= LEFT_I_RESET;
			ld_q <= LEFT_D_RESET;
			rp_q <= RIGHT_P_RESET;
			ri_q <= RIGHT_I_RESET;
			rd_q <= RIGHT_D_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LEFT_P:  lp_q <= $signed(cfg_data);
				REG_LEFT_I:  li_q <= $signed(cfg_data);
				REG_LEFT_D:  ld_q <= $signed(cfg_data);
				REG_RIGHT_P: rp_q <= $signed(cfg_data);
				REG_RIGHT_I: ri_q <= $signed(cfg_data);
				REG_RIGHT_D: rd_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign left_gains  = '{kp: lp_q, ki: li_q, kd: ld_q};
	assign right_gains = '{kp: rp_q, ki: ri_q, kd: rd_q};

	// Stage advance: ticks retire at stage one, control items flow to the output
	always_comb begin
		s3_go    = valid_s3 && (!out_valid_q || out_ready);
		s2_go    = valid_s2 && (!valid_s3 || s3_go);
		s1_go    = valid_s1 && ((cmd_s1 == CMD_TICK) || !valid_s2 || s2_go);
		in_ready = !valid_s1 || s1_go;
		accept   = in_valid && in_ready;
	end

	always_comb begin
		trk_ctl.tick_en = s1_go && (cmd_s1 == CMD_TICK);
		trk_ctl.ctrl_en = s1_go && (cmd_s1 == CMD_CONTROL);
		pid_ctl.mul_en  = s2_go;
		pid_ctl.out_en  = s3_go;
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (trk_ctl.ctrl_en) begin
				valid_s2 <= 1'b1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
			if (s2_go) begin
				valid_s3 <= 1'b1;
			end else if (s3_go) begin
				valid_s3 <= 1'b0;
			end
			if (s3_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input item register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(command);
			lraw_s1 <= left_raw_count;
			rraw_s1 <= right_raw_count;
			ltgt_s1 <= left_target;
			rtgt_s1 <= right_target;
		end
	end

	// Signed counts; the right encoder runs mirrored
	always_comb begin
		ldelta = unwrap_count(lraw_s1);
		rdelta = -unwrap_count(rraw_s1);
	end

	dwsp_track u_left_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (trk_ctl),
		.delta   (ldelta),
		.target  (ltgt_s1),
		.err_s2  (lerr_s2),
		.esum_s2 (lesum_s2),
		.diff_s2 (ldiff_s2)
	);

	dwsp_track u_right_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (trk_ctl),
		.delta   (rdelta),
		.target  (rtgt_s1),
		.err_s2  (rerr_s2),
		.esum_s2 (resum_s2),
		.diff_s2 (rdiff_s2)
	);

	dwsp_pid u_left_pid (
		.clk     (clk),
		.ctl     (pid_ctl),
		.gains   (left_gains),
		.err     (lerr_s2),
		.esum    (lesum_s2),
		.diff    (ldiff_s2),
		.drive_q (left_drive)
	);

	dwsp_pid u_right_pid (
		.clk     (clk),
		.ctl     (pid_ctl),
		.gains   (right_gains),
		.err     (rerr_s2),
		.esum    (resum_s2),
		.diff    (rdiff_s2),
		.drive_q (right_drive)
	);

	assign out_valid = out_valid_q;

`ifndef SYNTH
	// A control item leaving stage one always lands in stage two
	a_ctrl_reaches_s2: assert property (@(posedge clk) disable iff (!arst_n)
		trk_ctl.ctrl_en |=> valid_s2)
		else $error("control item lost between stage one and two");

	// A tick item never fills an empty stage two
	a_tick_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(trk_ctl.tick_en && !valid_s2) |=> !valid_s2)
		else $error("tick item produced a result slot");

	// A new result only follows a full stage three
	a_out_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s3))
		else $error("result appeared without an item in stage three");

	// An empty input register always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with an empty input register");
`endif

endmodule
